[design/etr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_pkg
// shared types and constants of the event timer register block
// ----------------------------------------------------------------------------
package etr_pkg;

	// request opcodes
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_PERIOD_FS      = 2'd0;
	localparam logic [1:0] CFG_LEGACY_CAPABLE = 2'd1;
	localparam logic [1:0] CFG_COUNTER_64     = 2'd2;
	localparam logic [1:0] CFG_ROUTE_MASK     = 2'd3;

	localparam int CFG_DATA_W = 32;
	localparam int PERIOD_W   = 27;
	localparam int ROUTE_CAP_W = 24;
	localparam int ROUTE_W    = 5;

	// register map, byte offsets
	localparam logic [10:0] REG_CAP     = 11'h000;
	localparam logic [10:0] REG_GEN_CFG = 11'h010;
	localparam logic [10:0] REG_STATUS  = 11'h020;
	localparam logic [10:0] REG_COUNTER = 11'h0F0;
	localparam int TIMER_CFG_BASE = 'h100;
	localparam int TIMER_CMP_BASE = 'h108;
	localparam int TIMER_STRIDE   = 'h20;

	// field positions
	localparam int ROUTE_LSB     = 9;
	localparam int ROUTE_CAP_LSB = 32;
	localparam int PERIOD_LSB    = 32;

	localparam logic [7:0]         REVISION_ID   = 8'd1;
	localparam logic [ROUTE_W-1:0] LEGACY_ROUTE0 = 5'd2;
	localparam logic [ROUTE_W-1:0] LEGACY_ROUTE1 = 5'd8;

	// configuration reset values
	localparam logic [PERIOD_W-1:0]    PERIOD_RESET    = 27'd69841279;
	localparam logic [ROUTE_CAP_W-1:0] ROUTE_CAP_RESET = 24'hffffff;

endpackage

[design/etr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_req_if
// request channel: bus read, bus write or counter tick
// ----------------------------------------------------------------------------
interface etr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [10:0] address;
	logic [63:0] write_data;

	modport source (output valid, output opcode, output address, output write_data,
		input ready);
	modport sink (input valid, input opcode, input address, input write_data,
		output ready);
endinterface

[design/etr_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_rsp_if
// response channel: read data and fired timers
// ----------------------------------------------------------------------------
interface etr_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_data;
	logic [2:0]  fire_mask;

	modport source (output valid, output read_data, output fire_mask, input ready);
	modport sink (input valid, input read_data, input fire_mask, output ready);
endinterface

[design/etr_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface etr_cfg_if
	import etr_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [1:0]            index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/event_timer_register_block_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_timer_register_block_top
// event timer register block: capability, general config, status, main
// counter and per timer config and comparator
// response: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle while rsp.ready is high; a stalled
// response holds off new requests, since there is one response register
// reset: arst_n clears counter, enables, routes and status, sets the
// comparators to all ones and loads the configuration defaults
// ----------------------------------------------------------------------------
module event_timer_register_block_top
	import etr_pkg::*;
#(
	parameter int NUM_TIMERS = 3
) (
	input  logic    clk,
	input  logic    arst_n,
	etr_req_if.sink   req,
	etr_rsp_if.source rsp,
	etr_cfg_if.sink   cfg
);

	// padded fire vector so that the three reported bits always exist
	localparam int FIRE_W = (NUM_TIMERS > 3) ? NUM_TIMERS : 3;

	// configuration registers
	logic [PERIOD_W-1:0]    period_q;
	logic                   legacy_cap_q;
	logic                   counter_64_q;
	logic [ROUTE_CAP_W-1:0] route_cap_q;

	// timer state
	logic [63:0]           count_q, count_d;
	logic                  cnt_en_q, cnt_en_d;
	logic                  legacy_on_q, legacy_on_d;
	logic [NUM_TIMERS-1:0] int_en_q, int_en_d;
	logic [NUM_TIMERS-1:0] level_q, level_d;
	logic [NUM_TIMERS-1:0] status_q, status_d;
	logic [ROUTE_W-1:0]    route_q [NUM_TIMERS];
	logic [ROUTE_W-1:0]    route_d [NUM_TIMERS];
	logic [63:0]           cmp_q [NUM_TIMERS];
	logic [63:0]           cmp_d [NUM_TIMERS];

	// response register
	logic        rsp_valid_q;
	logic [63:0] read_data_q, read_data_d;
	logic [2:0]  fire_mask_q, fire_mask_d;

	logic                  accept;
	logic [63:0]           cnt_mask;
	logic [63:0]           count_inc;
	logic                  legacy_act;
	logic [NUM_TIMERS-1:0] cfg_hit, cmp_hit, match;
	logic [FIRE_W-1:0]     fire_pad;
	logic [ROUTE_W-1:0]    eff_route [NUM_TIMERS];
	logic [31:0]           route_cap_ext;
	logic [ROUTE_W-1:0]    wr_route;
	logic [63:0]           rd_val;

	// a new request is taken whenever the response register is free or drains
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.fire_mask = fire_mask_q;

	// 32-bit mode: counter and comparators only use the low word
	assign cnt_mask   = counter_64_q ? '1 : {32'h0, 32'hffff_ffff};
	assign count_inc  = (count_q + 64'd1) & cnt_mask;
	assign legacy_act = legacy_on_q && legacy_cap_q;

	assign route_cap_ext = {8'h0, route_cap_q};
	assign wr_route      = req.write_data[ROUTE_LSB +: ROUTE_W];

	// per timer address decode, compare and effective route
	always_comb begin
		for (int n = 0; n < NUM_TIMERS; n++) begin
			cfg_hit[n] = (req.address == 11'(TIMER_CFG_BASE + TIMER_STRIDE * n));
			cmp_hit[n] = (req.address == 11'(TIMER_CMP_BASE + TIMER_STRIDE * n));
			match[n]   = ((cmp_q[n] & cnt_mask) == count_inc);
			if (legacy_act && n == 0) begin
				eff_route[n] = LEGACY_ROUTE0;
			end else if (legacy_act && n == 1) begin
				eff_route[n] = LEGACY_ROUTE1;
			end else begin
				eff_route[n] = route_q[n];
			end
		end
	end

	// read mux, unaligned and unmapped offsets read zero
	always_comb begin
		rd_val = '0;
		if (req.address == REG_CAP) begin
			rd_val[7:0]   = REVISION_ID;
			rd_val[12:8]  = 5'(NUM_TIMERS - 1);
			rd_val[13]    = counter_64_q;
			rd_val[15]    = legacy_cap_q;
			rd_val[PERIOD_LSB +: PERIOD_W] = period_q;
		end else if (req.address == REG_GEN_CFG) begin
			rd_val[0] = cnt_en_q;
			rd_val[1] = legacy_on_q;
		end else if (req.address == REG_STATUS) begin
			rd_val[NUM_TIMERS-1:0] = status_q;
		end else if (req.address == REG_COUNTER) begin
			rd_val = count_q & cnt_mask;
		end else begin
			for (int n = 0; n < NUM_TIMERS; n++) begin
				if (cfg_hit[n]) begin
					rd_val[1] = level_q[n];
					rd_val[2] = int_en_q[n];
					rd_val[5] = counter_64_q;
					rd_val[ROUTE_LSB +: ROUTE_W]         = eff_route[n];
					rd_val[ROUTE_CAP_LSB +: ROUTE_CAP_W] = route_cap_q;
				end
				if (cmp_hit[n]) begin
					rd_val = cmp_q[n] & cnt_mask;
				end
			end
		end
	end

	// next state and response for the request on the port
	always_comb begin
		count_d     = count_q;
		cnt_en_d    = cnt_en_q;
		legacy_on_d = legacy_on_q;
		int_en_d    = int_en_q;
		level_d     = level_q;
		status_d    = status_q;
		route_d     = route_q;
		cmp_d       = cmp_q;
		read_data_d = '0;
		fire_pad    = '0;
		case (req.opcode)
			OP_READ: begin
				read_data_d = rd_val;
			end
			OP_WRITE: begin
				if (req.address == REG_GEN_CFG) begin
					cnt_en_d = req.write_data[0];
					// legacy bit sticks only when the block supports it
					if (legacy_cap_q) begin
						legacy_on_d = req.write_data[1];
					end
				end else if (req.address == REG_STATUS) begin
					// write one to clear
					status_d = status_q & ~req.write_data[NUM_TIMERS-1:0];
				end else if (req.address == REG_COUNTER) begin
					count_d = req.write_data & cnt_mask;
				end else begin
					for (int n = 0; n < NUM_TIMERS; n++) begin
						if (cfg_hit[n]) begin
							level_d[n]  = req.write_data[1];
							int_en_d[n] = req.write_data[2];
							// a route outside the capability mask is dropped
							if (route_cap_ext[wr_route]) begin
								route_d[n] = wr_route;
							end
						end
						if (cmp_hit[n]) begin
							cmp_d[n] = req.write_data;
						end
					end
				end
			end
			OP_TICK: begin
				if (cnt_en_q) begin
					count_d  = count_inc;
					status_d = status_q | match;
					fire_pad = FIRE_W'(match & int_en_q);
				end
			end
			default: begin
			end
		endcase
		fire_mask_d = fire_pad[2:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RESET;
			legacy_cap_q <= 1'b1;
			counter_64_q <= 1'b1;
			route_cap_q  <= ROUTE_CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_PERIOD_FS:      period_q     <= cfg.data[PERIOD_W-1:0];
				CFG_LEGACY_CAPABLE: legacy_cap_q <= cfg.data[0];
				CFG_COUNTER_64:     counter_64_q <= cfg.data[0];
				CFG_ROUTE_MASK:     route_cap_q  <= cfg.data[ROUTE_CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// timer state, updated once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cnt_en_q    <= 1'b0;
			legacy_on_q <= 1'b0;
			int_en_q    <= '0;
			level_q     <= '0;
			status_q    <= '0;
			for (int n = 0; n < NUM_TIMERS; n++) begin
				route_q[n] <= '0;
				cmp_q[n]   <= '1;
			end
		end else if (accept) begin
			count_q     <= count_d;
			cnt_en_q    <= cnt_en_d;
			legacy_on_q <= legacy_on_d;
			int_en_q    <= int_en_d;
			level_q     <= level_d;
			status_q    <= status_d;
			route_q     <= route_d;
			cmp_q       <= cmp_d;
		end
	end

	// response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= read_data_d;
			fire_mask_q <= fire_mask_d;
		end
	end

endmodule

[design/etr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_checker
// port level checks of the event timer register block
// ----------------------------------------------------------------------------
module etr_checker
	import etr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_opcode,
	input logic [10:0] req_address,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_read_data,
	input logic [2:0]  rsp_fire_mask
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// a stalled response stays valid
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// every accepted request gets its response on the next cycle
	a_rsp_next: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("no response after accepted request");

	// an empty response register never blocks requests
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty response register");

	// only ticks fire timers
	a_fire_tick: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_opcode != OP_TICK |=> rsp_fire_mask == 3'd0)
		else $error("fire bits on a non-tick request");

	// unaligned reads return zero
	a_unaligned: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_address[2:0] != 3'd0 |=> rsp_read_data == 64'd0)
		else $error("unaligned read returned data");

endmodule

bind event_timer_register_block_top etr_checker u_etr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_opcode    (req.opcode),
	.req_address   (req.address),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_fire_mask (rsp.fire_mask)
);

[tb/etr_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_tb_pkg
// timer state predictor and response scoreboard for the event timer block
// ----------------------------------------------------------------------------
package etr_tb_pkg;
	import etr_pkg::*;

	typedef struct packed {
		logic [63:0] read_data;
		logic [2:0]  fire_mask;
	} timer_reply_t;

	class timer_scoreboard;
		localparam int TIMERS     = 3;
		localparam int MAX_REPORT = 10;

		// configuration
		logic [PERIOD_W-1:0]    period;
		logic                   legacy_cap;
		logic                   wide_count;
		logic [ROUTE_CAP_W-1:0] route_cap;

		// block state
		logic [63:0]        count;
		logic               cnt_en;
		logic               legacy_on;
		logic               int_en [TIMERS];
		logic               level  [TIMERS];
		logic [ROUTE_W-1:0] route  [TIMERS];
		logic [63:0]        compare [TIMERS];
		logic               status [TIMERS];

		timer_reply_t due_replies[$];
		int errors;
		int reads, writes, ticks, fires, replies;

		function new();
			period     = PERIOD_RESET;
			legacy_cap = 1'b1;
			wide_count = 1'b1;
			route_cap  = ROUTE_CAP_RESET;
			count      = '0;
			cnt_en     = 1'b0;
			legacy_on  = 1'b0;
			for (int n = 0; n < TIMERS; n++) begin
				int_en[n]  = 1'b0;
				level[n]   = 1'b0;
				route[n]   = '0;
				compare[n] = '1;
				status[n]  = 1'b0;
			end
			errors = 0;
			reads = 0; writes = 0; ticks = 0; fires = 0; replies = 0;
		endfunction

		function int pending();
			return due_replies.size();
		endfunction

		function void apply_setting(logic [1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_PERIOD_FS:      period     = data[PERIOD_W-1:0];
				CFG_LEGACY_CAPABLE: legacy_cap = data[0];
				CFG_COUNTER_64:     wide_count = data[0];
				CFG_ROUTE_MASK:     route_cap  = data[ROUTE_CAP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] count_mask();
			return wide_count ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
		endfunction

		function logic [ROUTE_W-1:0] shown_route(int n);
			if (legacy_on && legacy_cap && n == 0)
				return LEGACY_ROUTE0;
			if (legacy_on && legacy_cap && n == 1)
				return LEGACY_ROUTE1;
			return route[n];
		endfunction

		function logic [63:0] read_register(logic [10:0] addr);
			logic [63:0] v;
			int n;
			v = '0;
			if (addr[2:0] != 3'd0)
				return '0;
			if (addr == REG_CAP) begin
				v[7:0]   = REVISION_ID;
				v[12:8]  = 5'(TIMERS - 1);
				v[13]    = wide_count;
				v[15]    = legacy_cap;
				v[63:32] = 32'(period);
				return v;
			end
			if (addr == REG_GEN_CFG)
				return {62'd0, legacy_on, cnt_en};
			if (addr == REG_STATUS) begin
				for (n = 0; n < TIMERS; n++)
					v[n] = status[n];
				return v;
			end
			if (addr == REG_COUNTER)
				return count & count_mask();
			for (n = 0; n < TIMERS; n++) begin
				if (addr == 11'(TIMER_CFG_BASE + TIMER_STRIDE * n)) begin
					v[1] = level[n];
					v[2] = int_en[n];
					v[5] = wide_count;
					v[ROUTE_LSB +: ROUTE_W] = shown_route(n);
					v[ROUTE_CAP_LSB +: ROUTE_CAP_W] = route_cap;
					return v;
				end
				if (addr == 11'(TIMER_CMP_BASE + TIMER_STRIDE * n))
					return compare[n] & count_mask();
			end
			return '0;
		endfunction

		function void write_register(logic [10:0] addr, logic [63:0] d);
			logic [ROUTE_W-1:0] r;
			int n;
			r = d[ROUTE_LSB +: ROUTE_W];
			if (addr[2:0] != 3'd0)
				return;
			if (addr == REG_GEN_CFG) begin
				cnt_en = d[0];
				if (legacy_cap)
					legacy_on = d[1];
				return;
			end
			if (addr == REG_STATUS) begin
				// write one to clear
				for (n = 0; n < TIMERS; n++)
					if (d[n])
						status[n] = 1'b0;
				return;
			end
			if (addr == REG_COUNTER) begin
				count = d & count_mask();
				return;
			end
			for (n = 0; n < TIMERS; n++) begin
				if (addr == 11'(TIMER_CFG_BASE + TIMER_STRIDE * n)) begin
					level[n]  = d[1];
					int_en[n] = d[2];
					// disallowed route leaves the stored one
					if (r < 5'(ROUTE_CAP_W) && route_cap[r])
						route[n] = r;
					return;
				end
				if (addr == 11'(TIMER_CMP_BASE + TIMER_STRIDE * n)) begin
					compare[n] = d;
					return;
				end
			end
		endfunction

		function logic [2:0] advance_counter();
			logic [2:0]  fire;
			logic [63:0] m;
			int n;
			fire = '0;
			m = count_mask();
			if (!cnt_en)
				return '0;
			count = (count + 64'd1) & m;
			for (n = 0; n < TIMERS; n++) begin
				if ((compare[n] & m) == count) begin
					status[n] = 1'b1;
					if (int_en[n])
						fire[n] = 1'b1;
				end
			end
			return fire;
		endfunction

		// accepted request: update state, queue the reply it must produce
		function void note_request(logic [1:0] op, logic [10:0] addr, logic [63:0] data);
			timer_reply_t r;
			r = '0;
			if (op == OP_READ) begin
				r.read_data = read_register(addr);
				reads++;
			end else if (op == OP_WRITE) begin
				write_register(addr, data);
				writes++;
			end else if (op == OP_TICK) begin
				r.fire_mask = advance_counter();
				ticks++;
				if (r.fire_mask != 3'd0)
					fires++;
			end
			due_replies.push_back(r);
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= MAX_REPORT)
				$display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
		endfunction

		function void check_response(logic [63:0] read_data, logic [2:0] fire_mask);
			timer_reply_t want;
			if (due_replies.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORT)
					$display("%0t unexpected response: read_data %h fire_mask %b",
						$time, read_data, fire_mask);
				return;
			end
			want = due_replies.pop_front();
			replies++;
			if (read_data !== want.read_data)
				flag("read_data", want.read_data, read_data);
			if (fire_mask !== want.fire_mask)
				flag("fire_mask", 64'(want.fire_mask), 64'(fire_mask));
		endfunction
	endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the event timer register block: a directed pass
// over register map corners, then random bus traffic and ticks under several
// configuration settings, with random idle on both request and response sides
// ----------------------------------------------------------------------------
module tb;
	import etr_pkg::*;
	import etr_tb_pkg::*;

	localparam logic [1:0]  OP_NONE         = 2'd3;     // unused opcode
	localparam logic [10:0] ADDR_TOP        = 11'h7ff;
	localparam logic [10:0] ADDR_UNALIGNED  = 11'h001;
	localparam logic [63:0] GEN_ENABLE      = 64'h1;
	localparam logic [63:0] GEN_LEGACY      = 64'h2;
	localparam logic [63:0] TCFG_LEVEL      = 64'h2;
	localparam logic [63:0] TCFG_INT_EN     = 64'h4;
	localparam logic [63:0] ALL_ONES        = 64'hffff_ffff_ffff_ffff;
	localparam logic [31:0] LOW_ONES        = 32'hffff_ffff;
	localparam int          PERIOD_MAX      = 100000000;
	localparam int          PHASES          = 5;
	localparam int          ITEMS_PER_PHASE = 385;
	localparam int          IDLE_PCT        = 16;
	localparam int          DRAIN_SLACK     = 4;      // the response is registered
	localparam int          END_WAIT        = 2000;
	localparam int          CYCLE_LIMIT     = 200000;

	logic clk;
	logic arst_n;
	bit   steady;     // no idling on either side while set
	int   cycles;

	etr_req_if req_ch ();
	etr_rsp_if rsp_ch ();
	etr_cfg_if cfg_ch ();

	timer_scoreboard sb = new();

	event_timer_register_block_top #(.NUM_TIMERS(3)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// response side backpressure, off during the steady phase
	always @(posedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// monitor: note accepted requests first, a same-edge response is older
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.apply_setting(cfg_ch.index, cfg_ch.data);
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.opcode, req_ch.address, req_ch.write_data);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.read_data, rsp_ch.fire_mask);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [10:0] timer_cfg_addr(int n);
		return 11'(TIMER_CFG_BASE + TIMER_STRIDE * n);
	endfunction

	function automatic logic [10:0] timer_cmp_addr(int n);
		return 11'(TIMER_CMP_BASE + TIMER_STRIDE * n);
	endfunction

	// one of the mapped registers, k in 0..9
	function automatic logic [10:0] mapped_addr(int k);
		case (k)
			0: return REG_CAP;
			1: return REG_GEN_CFG;
			2: return REG_STATUS;
			3: return REG_COUNTER;
			4, 5, 6: return timer_cfg_addr(k - 4);
			default: return timer_cmp_addr(k - 7);
		endcase
	endfunction

	// present one request, hold it until accepted; valid stays high after
	task automatic send_request(input logic [1:0] op, input logic [10:0] addr,
			input logic [63:0] data);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.address    <= addr;
		req_ch.write_data <= data;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// stop sending and let every outstanding response come back
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_setting(input logic [1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// corners of the register map at reset configuration
	task automatic run_directed();
		// capability, config, counter and comparator 0 at reset
		send_request(OP_READ, REG_CAP, '0);
		send_request(OP_READ, REG_GEN_CFG, '0);
		send_request(OP_READ, REG_COUNTER, '0);
		send_request(OP_READ, timer_cmp_addr(0), '0);
		// unaligned, top of address space, nonexistent timer
		send_request(OP_READ, ADDR_UNALIGNED, ALL_ONES);
		send_request(OP_READ, ADDR_TOP, '0);
		send_request(OP_READ, timer_cfg_addr(3), '0);
		// unused opcode does nothing
		send_request(OP_NONE, REG_COUNTER, ALL_ONES);
		// tick with the counter stopped
		send_request(OP_TICK, '0, '0);
		// capability is read only
		send_request(OP_WRITE, REG_CAP, ALL_ONES);
		send_request(OP_WRITE, REG_GEN_CFG, GEN_ENABLE | GEN_LEGACY);
		send_request(OP_WRITE, timer_cfg_addr(0),
			TCFG_LEVEL | TCFG_INT_EN | (64'd5 << ROUTE_LSB));
		// route 31 is never allowed, stored route stays
		send_request(OP_WRITE, timer_cfg_addr(1), TCFG_INT_EN | (64'd31 << ROUTE_LSB));
		// legacy routing overrides timers 0 and 1
		send_request(OP_READ, timer_cfg_addr(0), '0);
		send_request(OP_READ, timer_cfg_addr(1), '0);
		// two timers match on the same tick
		send_request(OP_WRITE, timer_cmp_addr(0), 64'd2);
		send_request(OP_WRITE, timer_cmp_addr(1), 64'd2);
		send_request(OP_TICK, '0, '0);
		send_request(OP_TICK, '0, '0);
		send_request(OP_READ, REG_STATUS, '0);
		send_request(OP_WRITE, REG_STATUS, 64'd1);
		// 64-bit wrap hits a comparator of zero, interrupt off
		send_request(OP_WRITE, REG_COUNTER, ALL_ONES);
		send_request(OP_WRITE, timer_cmp_addr(2), '0);
		send_request(OP_TICK, '0, '0);
		send_request(OP_READ, REG_STATUS, '0);
		// legacy off brings back the stored route; unaligned write ignored
		send_request(OP_WRITE, REG_GEN_CFG, GEN_ENABLE);
		send_request(OP_WRITE, timer_cmp_addr(0) | 11'd1, '0);
		send_request(OP_READ, timer_cfg_addr(0), '0);
	endtask

	task automatic apply_phase_settings(int phase);
		case (phase)
			0: begin
				write_setting(CFG_PERIOD_FS, 32'd1);
				write_setting(CFG_LEGACY_CAPABLE, 32'd1);
				write_setting(CFG_COUNTER_64, 32'd1);
				write_setting(CFG_ROUTE_MASK, 32'(ROUTE_CAP_RESET));
			end
			1: begin
				write_setting(CFG_PERIOD_FS, 32'(PERIOD_MAX));
				write_setting(CFG_LEGACY_CAPABLE, 32'd0);
				write_setting(CFG_COUNTER_64, 32'd0);
				write_setting(CFG_ROUTE_MASK, 32'd0);
			end
			2: begin
				write_setting(CFG_PERIOD_FS, 32'($urandom_range(1, PERIOD_MAX)));
				write_setting(CFG_LEGACY_CAPABLE, 32'd1);
				write_setting(CFG_COUNTER_64, 32'd0);
				write_setting(CFG_ROUTE_MASK, 32'($urandom_range(0, ROUTE_CAP_RESET)));
			end
			3: begin
				write_setting(CFG_PERIOD_FS, 32'(PERIOD_RESET));
				write_setting(CFG_LEGACY_CAPABLE, 32'd0);
				write_setting(CFG_COUNTER_64, 32'd1);
				write_setting(CFG_ROUTE_MASK, 32'($urandom_range(0, ROUTE_CAP_RESET)));
			end
			default: begin
				write_setting(CFG_PERIOD_FS, 32'($urandom_range(1, PERIOD_MAX)));
				write_setting(CFG_LEGACY_CAPABLE, 32'd1);
				write_setting(CFG_COUNTER_64, 32'd1);
				write_setting(CFG_ROUTE_MASK, 32'(ROUTE_CAP_RESET));
			end
		endcase
	endtask

	// mostly meaningful traffic: ticks, reads of mapped registers, and writes
	// that steer the counter and comparators close to each other so matches
	// and wraps happen often; the rest is noise
	task automatic random_request();
		int pick, t, k;
		logic [63:0] d;
		logic [10:0] a;
		pick = $urandom_range(0, 99);
		t    = $urandom_range(0, 2);
		k    = $urandom_range(1, 6);
		d    = rand64();
		if (pick < 32) begin
			send_request(OP_TICK, 11'($urandom_range(0, 2047)), d);
		end else if (pick < 58) begin
			a = mapped_addr($urandom_range(0, 9));
			if ($urandom_range(0, 19) == 0)
				a = a | 11'($urandom_range(1, 7));
			send_request(OP_READ, a, d);
		end else if (pick < 90) begin
			case ($urandom_range(0, 6))
				0: begin
					// keep the counter running most of the time
					d[0] = ($urandom_range(0, 9) != 0);
					a = REG_GEN_CFG;
				end
				1: a = REG_STATUS;
				2: begin
					// just below a comparator
					d[63:0] = sb.compare[t] - 64'(k);
					if (!sb.wide_count)
						d[63:32] = $urandom;
					a = REG_COUNTER;
				end
				3: begin
					// just below the wrap point
					if (sb.wide_count)
						d = ALL_ONES - 64'(k);
					else
						d[31:0] = LOW_ONES - 32'(k);
					a = REG_COUNTER;
				end
				4: begin
					d[2] = ($urandom_range(0, 3) != 0);
					a = timer_cfg_addr(t);
				end
				default: begin
					// comparator a few ticks ahead
					if ($urandom_range(0, 4) != 0) begin
						d[31:0] = sb.count[31:0] + 32'(k);
						if (sb.wide_count)
							d[63:32] = sb.count[63:32] + {31'd0, (d[31:0] < 32'(k))};
					end
					a = timer_cmp_addr(t);
				end
			endcase
			send_request(OP_WRITE, a, d);
		end else begin
			send_request(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)), d);
		end
	endtask

	initial begin
		int phase, n, guard;
		steady            = 1'b0;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.opcode     <= OP_READ;
		req_ch.address    <= '0;
		req_ch.write_data <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= CFG_PERIOD_FS;
		cfg_ch.data       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// random phases, one configuration setting each; the second phase
		// runs with no idling on either side
		for (phase = 0; phase < PHASES; phase++) begin
			drain_responses();
			steady = (phase == 1);
			apply_phase_settings(phase);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// occasionally hold off until the block has answered everything
				if ($urandom_range(0, 149) == 0)
					drain_responses();
				random_request();
			end
		end

		req_ch.valid <= 1'b0;
		steady = 1'b1;
		guard = 0;
		while (sb.pending() != 0 && guard < END_WAIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_SLACK) @(posedge clk);

		if (sb.pending() != 0)
			$display("%0d expected responses never arrived", sb.pending());
		$display("covered %0d requests: %0d reads, %0d writes, %0d ticks, %0d firing ticks",
			sb.reads + sb.writes + sb.ticks, sb.reads, sb.writes, sb.ticks, sb.fires);
		$display("%0d responses checked over %0d configuration settings, %0d mismatches",
			sb.replies, PHASES + 1, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
